// ----- rtl/tmtc_pkg.sv -----
// ----------------------------------------------------------------------------
// Tempo map converter package
// Shared types, constants and helpers for the tick and time converter.
// ----------------------------------------------------------------------------
package tmtc_pkg;

	localparam int unsigned MAX_EVENTS_DEF = 64;
	localparam int unsigned FRAC_BITS_DEF  = 16;

	// Input command codes
	localparam logic [2:0] CMD_CLEAR    = 3'd0;
	localparam logic [2:0] CMD_INSERT   = 3'd1;
	localparam logic [2:0] CMD_TO_TIME  = 3'd2;
	localparam logic [2:0] CMD_TO_TICK  = 3'd3;
	localparam logic [2:0] CMD_DURATION = 3'd4;

	// Result status codes
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_BAD_TEMPO  = 2'd1;
	localparam logic [1:0] STAT_TABLE_FULL = 2'd2;

	// Configuration register indexes
	localparam logic CFG_TICKS_PER_BEAT = 1'b0;
	localparam logic CFG_DEFAULT_BPM    = 1'b1;

	localparam logic [15:0] TPB_RESET        = 16'd480;
	localparam logic [19:0] BPM_LO           = 20'd1000;
	localparam logic [19:0] BPM_HI           = 20'd1000000;
	localparam logic [19:0] BPM_RESET        = 20'd120000;
	localparam logic [25:0] QUARTER_RESET    = 26'd500000;
	localparam logic [35:0] US_PER_MIN_MILLI = 36'd60000000000;
	localparam logic [62:0] TIME_MAX         = {63{1'b1}};
	localparam logic [30:0] TICK_MAX         = {31{1'b1}};

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] tick;
		logic signed [31:0] end_tick;
		logic [19:0]        bpm_milli;
		logic [62:0]        time_in;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [62:0] time_out;
		logic [30:0] tick_out;
		logic [19:0] bpm_out;
	} out_t;

	typedef enum logic [2:0] {
		KIND_CLEAR,
		KIND_INSERT,
		KIND_TO_TIME,
		KIND_TO_TICK,
		KIND_DURATION,
		KIND_NONE
	} kind_e;

	// Classified command as it waits in the queue
	typedef struct packed {
		kind_e       kind;
		logic        tempo_ok;
		logic [30:0] t0;
		logic [30:0] t1;
		logic [19:0] bpm;
		logic [62:0] time_in;
	} item_t;

	typedef struct packed {
		logic [30:0] start;
		logic [19:0] tempo;
		logic [25:0] quarter;
	} entry_t;

	typedef struct packed {
		logic [15:0] ticks_per_beat;
		logic [19:0] default_bpm;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_Q_DIV,
		ST_Q_WAIT,
		ST_CLR_WR,
		ST_INS_RD,
		ST_INS_CHK,
		ST_INS_DEC,
		ST_MV_RD,
		ST_MV_WR,
		ST_WALK_START,
		ST_WALK_CUR,
		ST_WALK_NXT,
		ST_TT_CHK,
		ST_TT_END,
		ST_TK_CHK,
		ST_SEG_MUL,
		ST_SEG_DIV,
		ST_SEG_WAIT,
		ST_TK_MUL,
		ST_TK_DIV,
		ST_TK_WAIT,
		ST_BPM_START,
		ST_BPM_RD,
		ST_BPM_CHK,
		ST_DONE
	} state_e;

	function automatic logic bpm_ok(input logic [19:0] m);
		return (m >= BPM_LO) && (m <= BPM_HI);
	endfunction

	function automatic logic [30:0] clamp_tick(input logic signed [31:0] raw);
		return raw[31] ? 31'd0 : raw[30:0];
	endfunction

endpackage

// ----- rtl/tmtc_div.sv -----
// ----------------------------------------------------------------------------
// Tempo map converter divider
// Restoring divider, one quotient bit per cycle, with a half-up rounding flag.
// ----------------------------------------------------------------------------
module tmtc_div #(
	parameter int unsigned NUM_W = 79,
	parameter int unsigned DEN_W = 42
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic             half
);
	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] nq_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, nq_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			nq_q  <= {nq_q[NUM_W-2:0], ge};
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = nq_q;
	// Round half up: twice the remainder reaches the divisor.
	assign half = {rem_q, 1'b0} >= {1'b0, den_q};

endmodule

// ----- rtl/tmtc_queue.sv -----
// ----------------------------------------------------------------------------
// Tempo map converter command queue
// Two-entry queue between the classifying front end and the sequencer.
// ----------------------------------------------------------------------------
module tmtc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tmtc_pkg::item_t      push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output tmtc_pkg::item_t      pop_data
);
	import tmtc_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full      = fill_q == 2'd2;
	assign not_empty = fill_q != 2'd0;
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/tmtc_front.sv -----
// ----------------------------------------------------------------------------
// Tempo map converter front end
// Takes command beats, clamps ticks, checks tempos and queues the result.
// ----------------------------------------------------------------------------
module tmtc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tmtc_pkg::in_t     in_data,
	input  logic [19:0]       default_bpm,
	output logic              push,
	output tmtc_pkg::item_t   push_data,
	input  logic              q_full
);
	import tmtc_pkg::*;

	item_t       item_s1;
	logic        valid_s1;
	item_t       cls;
	logic [30:0] t0;
	logic [30:0] t1;

	always_comb begin
		t0 = clamp_tick(in_data.tick);
		t1 = clamp_tick(in_data.end_tick);
		if (t1 < t0) begin
			t1 = t0;
		end
		cls.t0       = t0;
		cls.t1       = t1;
		cls.time_in  = in_data.time_in;
		cls.tempo_ok = bpm_ok(in_data.bpm_milli);
		cls.bpm      = in_data.bpm_milli;
		case (in_data.command)
			CMD_CLEAR: begin
				cls.kind     = KIND_CLEAR;
				// Fallback chain: given tempo, then default register, then reset tempo.
				cls.tempo_ok = 1'b1;
				if (bpm_ok(in_data.bpm_milli)) begin
					cls.bpm = in_data.bpm_milli;
				end else if (bpm_ok(default_bpm)) begin
					cls.bpm = default_bpm;
				end else begin
					cls.bpm = BPM_RESET;
				end
			end
			CMD_INSERT:   cls.kind = KIND_INSERT;
			CMD_TO_TIME:  cls.kind = KIND_TO_TIME;
			CMD_TO_TICK:  cls.kind = KIND_TO_TICK;
			CMD_DURATION: cls.kind = KIND_DURATION;
			default:      cls.kind = KIND_NONE;
		endcase
	end

	assign push      = valid_s1 && !q_full;
	assign push_data = item_s1;
	assign in_ready  = !valid_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= cls;
		end
	end

endmodule

// ----- rtl/tmtc_back.sv -----
// ----------------------------------------------------------------------------
// Tempo map converter back end
// Sequencer that owns the tempo table and walks it for each command.
// ----------------------------------------------------------------------------
module tmtc_back #(
	parameter int unsigned MAX_EVENTS = 64,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tmtc_pkg::cfg_t    cfg,
	input  logic              q_valid,
	input  tmtc_pkg::item_t   q_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output tmtc_pkg::out_t    out_data
);
	import tmtc_pkg::*;

	localparam int unsigned AW    = $clog2(MAX_EVENTS);
	localparam int unsigned CW    = $clog2(MAX_EVENTS + 1);
	localparam int unsigned SEG_W = 57 + FRAC_BITS;
	localparam int unsigned NUM_W = (SEG_W > 79) ? SEG_W : 79;
	localparam int unsigned DEN_W = 26 + FRAC_BITS;

	state_e state_q, state_d;

	// Entry 0 always starts at tick 0; its tempo lives in flops so reset defines it.
	entry_t      mem [MAX_EVENTS];
	entry_t      mem_rd_q;
	logic        rd_zero_q;
	logic [19:0] tempo0_q;
	logic [25:0] quarter0_q;
	entry_t      rd_entry;

	logic [AW-1:0] raddr;
	logic          wr_en;
	logic [AW-1:0] waddr;
	entry_t        wdata;

	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic             div_done;
	logic [NUM_W-1:0] div_quo;
	logic             div_half;
	logic [62:0]      md_res;

	item_t       it_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] k_next;
	logic [AW-1:0] j_q;
	logic          eq_q;
	logic          pass_q;
	logic [25:0]   qnew_q;
	logic [30:0]   cur_s_q;
	logic [25:0]   cur_q_q;
	logic [30:0]   nxt_s_q;
	logic [25:0]   nxt_q_q;
	logic [30:0]   seg_end_q;
	logic [30:0]   target_q;
	logic [62:0]   acc_q;
	logic [62:0]   a_q;
	logic [62:0]   rem_q;
	logic [NUM_W-1:0] mul_q;
	logic [1:0]    status_q;
	logic [62:0]   tout_q;
	logic [30:0]   kout_q;
	logic [19:0]   bpm_res_q;
	logic          out_valid_q;
	out_t          out_q;

	logic [15:0] tpb;
	logic [30:0] seg_e;
	logic [56:0] seg_prod;
	logic [78:0] tk_prod;
	logic [63:0] acc_sum;
	logic        load_out;
	logic        is_tt;

	assign tpb      = (cfg.ticks_per_beat == 16'd0) ? 16'd1 : cfg.ticks_per_beat;
	assign rd_entry = rd_zero_q ? entry_t'{start: 31'd0, tempo: tempo0_q, quarter: quarter0_q}
	                            : mem_rd_q;
	assign k_next   = k_q + 1'b1;
	assign seg_e    = (target_q < seg_end_q) ? target_q : seg_end_q;
	assign seg_prod = (seg_e - cur_s_q) * cur_q_q;
	assign tk_prod  = rem_q * tpb;
	assign acc_sum  = {1'b0, acc_q} + {1'b0, md_res};
	assign md_res   = (div_quo >= NUM_W'(TIME_MAX)) ? TIME_MAX
	                                                : div_quo[62:0] + 63'(div_half);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign is_tt    = (it_q.kind == KIND_TO_TIME) || (it_q.kind == KIND_DURATION);

	tmtc_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.half   (div_half)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_data.kind)
						KIND_CLEAR:    state_d = ST_Q_DIV;
						KIND_INSERT:   state_d = q_data.tempo_ok ? ST_Q_DIV : ST_BPM_START;
						KIND_TO_TIME:  state_d = ST_WALK_START;
						KIND_DURATION: state_d = ST_WALK_START;
						KIND_TO_TICK: begin
							state_d = (q_data.time_in == 63'd0) ? ST_BPM_START : ST_WALK_START;
						end
						default:       state_d = ST_BPM_START;
					endcase
				end
			end
			ST_Q_DIV:  state_d = ST_Q_WAIT;
			ST_Q_WAIT: begin
				if (div_done) begin
					state_d = (it_q.kind == KIND_CLEAR) ? ST_CLR_WR : ST_INS_RD;
				end
			end
			ST_CLR_WR: state_d = ST_BPM_START;
			ST_INS_RD: state_d = (k_q == count_q) ? ST_INS_DEC : ST_INS_CHK;
			ST_INS_CHK: begin
				state_d = (rd_entry.start >= it_q.t0) ? ST_INS_DEC : ST_INS_RD;
			end
			ST_INS_DEC: begin
				if (eq_q) begin
					state_d = ST_BPM_START;
				end else if (count_q >= CW'(MAX_EVENTS)) begin
					state_d = ST_BPM_START;
				end else begin
					state_d = ST_MV_RD;
				end
			end
			ST_MV_RD: state_d = (CW'(j_q) == k_q) ? ST_BPM_START : ST_MV_WR;
			ST_MV_WR: state_d = ST_MV_RD;
			ST_WALK_START: state_d = ST_WALK_CUR;
			ST_WALK_CUR:   state_d = is_tt ? ST_TT_CHK : ST_TK_CHK;
			ST_WALK_NXT:   state_d = ST_SEG_MUL;
			ST_TT_CHK: begin
				if (target_q <= cur_s_q) begin
					state_d = ST_TT_END;
				end else if (k_next < count_q) begin
					state_d = ST_WALK_NXT;
				end else begin
					state_d = ST_SEG_MUL;
				end
			end
			ST_TT_END: begin
				state_d = (it_q.kind == KIND_DURATION && !pass_q) ? ST_WALK_START : ST_BPM_START;
			end
			ST_TK_CHK:  state_d = (k_next >= count_q) ? ST_TK_MUL : ST_WALK_NXT;
			ST_SEG_MUL: state_d = ST_SEG_DIV;
			ST_SEG_DIV: state_d = ST_SEG_WAIT;
			ST_SEG_WAIT: begin
				if (div_done) begin
					if (is_tt) begin
						state_d = (target_q <= seg_end_q) ? ST_TT_END : ST_TT_CHK;
					end else begin
						state_d = (rem_q <= md_res) ? ST_TK_MUL : ST_TK_CHK;
					end
				end
			end
			ST_TK_MUL: state_d = ST_TK_DIV;
			ST_TK_DIV: state_d = ST_TK_WAIT;
			ST_TK_WAIT: begin
				if (div_done) begin
					state_d = ST_BPM_START;
				end
			end
			ST_BPM_START: state_d = ST_BPM_RD;
			ST_BPM_RD:    state_d = (k_q == count_q) ? ST_DONE : ST_BPM_CHK;
			ST_BPM_CHK:   state_d = (rd_entry.start <= it_q.t0) ? ST_BPM_RD : ST_DONE;
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs to the queue, the table and the divider
	always_comb begin
		pop       = 1'b0;
		raddr     = k_q[AW-1:0];
		wr_en     = 1'b0;
		waddr     = k_q[AW-1:0];
		wdata     = entry_t'{start: it_q.t0, tempo: it_q.bpm, quarter: qnew_q};
		div_start = 1'b0;
		div_num   = mul_q << FRAC_BITS;
		div_den   = DEN_W'(tpb);
		case (state_q)
			ST_IDLE: pop = q_valid;
			ST_Q_DIV: begin
				div_start = 1'b1;
				div_num   = NUM_W'(US_PER_MIN_MILLI) + NUM_W'(it_q.bpm >> 1);
				div_den   = DEN_W'(it_q.bpm);
			end
			ST_CLR_WR: begin
				wr_en = 1'b1;
				waddr = '0;
				wdata = entry_t'{start: 31'd0, tempo: it_q.bpm, quarter: qnew_q};
			end
			ST_INS_DEC: wr_en = eq_q;
			ST_MV_RD: begin
				raddr = j_q - 1'b1;
				if (CW'(j_q) == k_q) begin
					wr_en = 1'b1;
				end
			end
			ST_MV_WR: begin
				wr_en = 1'b1;
				waddr = j_q;
				wdata = rd_entry;
			end
			ST_WALK_START: raddr = '0;
			ST_TT_CHK:     raddr = k_next[AW-1:0];
			ST_TK_CHK:     raddr = k_next[AW-1:0];
			ST_SEG_DIV:    div_start = 1'b1;
			ST_TK_DIV: begin
				div_start = 1'b1;
				div_num   = mul_q;
				div_den   = DEN_W'(cur_q_q) << FRAC_BITS;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= CW'(1);
			tempo0_q    <= BPM_RESET;
			quarter0_q  <= QUARTER_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en && waddr == '0) begin
				tempo0_q   <= wdata.tempo;
				quarter0_q <= wdata.quarter;
			end
			if (state_q == ST_CLR_WR) begin
				count_q <= CW'(1);
			end else if (state_q == ST_MV_RD && CW'(j_q) == k_q) begin
				count_q <= count_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && waddr != '0) begin
			mem[waddr] <= wdata;
		end
		mem_rd_q  <= mem[raddr];
		rd_zero_q <= raddr == '0;
	end

	// Sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				it_q     <= q_data;
				status_q <= (q_data.kind == KIND_INSERT && !q_data.tempo_ok) ? STAT_BAD_TEMPO
				                                                             : STAT_OK;
				tout_q   <= '0;
				kout_q   <= '0;
				pass_q   <= 1'b0;
				rem_q    <= q_data.time_in;
				target_q <= (q_data.kind == KIND_TO_TICK) ? TICK_MAX : q_data.t0;
				k_q      <= '0;
			end
			ST_Q_WAIT: begin
				qnew_q <= div_quo[25:0];
				k_q    <= '0;
			end
			ST_INS_CHK: begin
				if (rd_entry.start >= it_q.t0) begin
					eq_q <= rd_entry.start == it_q.t0;
				end else begin
					k_q <= k_next;
				end
			end
			ST_INS_RD: begin
				if (k_q == count_q) begin
					eq_q <= 1'b0;
				end
			end
			ST_INS_DEC: begin
				j_q <= count_q[AW-1:0];
				if (!eq_q && count_q >= CW'(MAX_EVENTS)) begin
					status_q <= STAT_TABLE_FULL;
				end
			end
			ST_MV_WR: j_q <= j_q - 1'b1;
			ST_WALK_START: begin
				acc_q <= '0;
				k_q   <= '0;
			end
			ST_WALK_CUR: begin
				cur_s_q <= rd_entry.start;
				cur_q_q <= rd_entry.quarter;
			end
			ST_TT_CHK: begin
				seg_end_q <= target_q;
			end
			ST_WALK_NXT: begin
				nxt_s_q   <= rd_entry.start;
				nxt_q_q   <= rd_entry.quarter;
				seg_end_q <= rd_entry.start;
			end
			ST_SEG_MUL: mul_q <= NUM_W'(seg_prod);
			ST_SEG_WAIT: begin
				if (div_done) begin
					if (is_tt) begin
						acc_q <= acc_sum[63] ? TIME_MAX : acc_sum[62:0];
						if (!(target_q <= seg_end_q)) begin
							cur_s_q <= nxt_s_q;
							cur_q_q <= nxt_q_q;
							k_q     <= k_next;
						end
					end else if (!(rem_q <= md_res)) begin
						rem_q   <= rem_q - md_res;
						cur_s_q <= nxt_s_q;
						cur_q_q <= nxt_q_q;
						k_q     <= k_next;
					end
				end
			end
			ST_TT_END: begin
				if (it_q.kind == KIND_DURATION && !pass_q) begin
					a_q      <= acc_q;
					pass_q   <= 1'b1;
					target_q <= it_q.t1;
				end else if (it_q.kind == KIND_DURATION) begin
					tout_q <= (acc_q > a_q) ? acc_q - a_q : 63'd0;
				end else begin
					tout_q <= acc_q;
				end
			end
			ST_TK_MUL: mul_q <= NUM_W'(tk_prod);
			ST_TK_WAIT: begin
				if (div_done) begin
					if (md_res > {32'd0, TICK_MAX - cur_s_q}) begin
						kout_q <= TICK_MAX;
					end else begin
						kout_q <= cur_s_q + md_res[30:0];
					end
				end
			end
			ST_BPM_START: k_q <= '0;
			ST_BPM_CHK: begin
				// The table is sorted, so the last start at or below the tick wins.
				if (rd_entry.start <= it_q.t0) begin
					bpm_res_q <= rd_entry.tempo;
					k_q       <= k_next;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					out_q <= out_t'{status: status_q, time_out: tout_q, tick_out: kout_q,
					                bpm_out: bpm_res_q};
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- rtl/tempo_map_tick_time_converter_unit.sv -----
// ----------------------------------------------------------------------------
// Tempo map tick and time converter
// Holds a tick-sorted tempo table and converts between ticks and time.
// ----------------------------------------------------------------------------
// Usage: command beats arrive on in_valid/in_ready with in_data, and one
// result beat per command leaves on out_valid/out_ready with out_data.
// A front stage classifies each beat into a two-entry queue; a sequencer
// behind it owns the table and runs one command at a time.
// Each command ends with a tempo look-up that reads the table entry by entry
// up to the queried tick. Clear, and insert with a valid tempo, add a
// quarter-length division; an insert of a new tick also moves each later
// entry up one place. A conversion runs a division per segment walked, and
// a duration walks twice; all divisions share one iterative divider, which
// sets the throughput.
// Reset empties the queue and leaves one entry at tick 0, 120 BPM, with 480
// ticks per beat. A stalled receiver holds the result in the output register;
// the sequencer then waits; queue and front stage take up to 3 more beats.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once.
// ----------------------------------------------------------------------------
module tempo_map_tick_time_converter_unit #(
	parameter int unsigned MAX_EVENTS = tmtc_pkg::MAX_EVENTS_DEF,
	parameter int unsigned FRAC_BITS  = tmtc_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tmtc_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output tmtc_pkg::out_t out_data,
	input  logic           cfg_wr_en,
	input  logic           cfg_index,
	input  logic [19:0]    cfg_data
);
	import tmtc_pkg::*;

	cfg_t  cfg_q;
	logic  push;
	item_t push_data;
	logic  q_full;
	logic  pop;
	logic  q_valid;
	item_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_beat <= TPB_RESET;
			cfg_q.default_bpm    <= BPM_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TICKS_PER_BEAT: cfg_q.ticks_per_beat <= cfg_data[15:0];
				CFG_DEFAULT_BPM:    cfg_q.default_bpm    <= cfg_data;
				default: ;
			endcase
		end
	end

	tmtc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.default_bpm (cfg_q.default_bpm),
		.push        (push),
		.push_data   (push_data),
		.q_full      (q_full)
	);

	tmtc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	tmtc_back #(
		.MAX_EVENTS (MAX_EVENTS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
